[hdl/hashed_lru_block_buffer_cache_macros.svh]
// Assertion macros for the hashed LRU buffer cache tag store.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define HASHED_LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define HLBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HLBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HLBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/hlbc_pkg.sv]
// Package for the hashed LRU buffer cache: word types, codes and geometry.
// No dependencies.
`timescale 1ns / 1ps
package hlbc_pkg;
  // Cache geometry and bucket hash
  localparam int NUM_BUCKETS     = 13;
  localparam int WAYS            = 4;
  localparam int HASH_MULTIPLIER = 17;
  localparam int SLOTS           = NUM_BUCKETS * WAYS;

  localparam logic [1:0] KIND_GET     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_PIN     = 2'd2;
  localparam logic [1:0] KIND_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  device_id;
    logic [23:0] block_number;
    logic [5:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [5:0] slot;
    logic       hit;
    logic       needs_read;
    logic [1:0] status;
  } rsp_t;

  // Classified command handed from front to back.
  typedef struct packed {
    req_t       req;
    logic [5:0] bucket;   // bucket number
    logic       in_range; // buffer_index below slot count
  } cmd_t;
endpackage

[hdl/hlbc_front.sv]
// Front end: takes a request word, hashes the block to a bucket by a
// reciprocal quotient and a small remainder table, pushes a classified command.
// Depends on hlbc_pkg.
`timescale 1ns / 1ps
module hlbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  hlbc_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            push_o,
  output hlbc_pkg::cmd_t  cmd_o,
  input  logic            full_i
);
  import hlbc_pkg::*;
  localparam int QSH = 30;       // block bits plus six: exact for any bucket count
  localparam logic [30:0] RECIP =
    31'(((64'd1 << QSH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_REM = 3'b010, S_PUSH = 3'b100
  } fst_e;

  fst_e        st_q, st_d;
  req_t        req_q;
  logic [23:0] quo_q;
  logic [5:0]  bkt_q, bkt_d;
  logic [53:0] prod;
  logic [23:0] rmd;

  // block / NUM_BUCKETS by reciprocal multiply
  assign prod = 54'(req_i.block_number) * 54'(RECIP);

  // block mod NUM_BUCKETS, then (rmd * HASH_MULTIPLIER) mod NUM_BUCKETS by table
  assign rmd = req_q.block_number - quo_q * 24'(NUM_BUCKETS);
  always_comb begin
    bkt_d = '0;
    for (int i = 0; i < NUM_BUCKETS; i++)
      if (rmd == 24'(i)) bkt_d = 6'((i * HASH_MULTIPLIER) % NUM_BUCKETS);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (start_i) st_d = S_REM;
      S_REM: st_d = S_PUSH;
      S_PUSH: if (!full_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      req_q <= req_i;
      quo_q <= 24'(prod >> QSH);
    end
    if (st_q == S_REM) bkt_q <= bkt_d;
  end

  assign busy_o = (st_q != S_IDLE);
  assign push_o = (st_q == S_PUSH) && !full_i;
  always_comb begin
    cmd_o.req = req_q;
    cmd_o.bucket = (req_q.kind == KIND_GET) ? bkt_q
                 : 6'(req_q.buffer_index / 6'(WAYS));
    cmd_o.in_range = (32'(req_q.buffer_index) < 32'(SLOTS));
  end
endmodule

[hdl/hlbc_queue.sv]
// Two-entry command queue between front and back.
// Depends on hlbc_pkg.
`timescale 1ns / 1ps
module hlbc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hlbc_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output hlbc_pkg::cmd_t cmd_o
);
  import hlbc_pkg::*;
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end
  assign full_o = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o = mem_q[rp_q];
endmodule

[hdl/hlbc_back.sv]
// Back end: reads a bucket row, compares all ways, writes the row back when
// it changes and strobes the result word. Depends on hlbc_pkg.
`timescale 1ns / 1ps
module hlbc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  hlbc_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           idle_o,
  output logic           done_o,
  output hlbc_pkg::rsp_t rsp_o
);
  import hlbc_pkg::*;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  typedef struct packed {
    logic [7:0]  dev;
    logic [23:0] blk;
    logic        vld;
    logic [7:0]  cnt;
    logic [WW-1:0] rank;
  } way_t;
  typedef way_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001, B_READ = 3'b010, B_EXEC = 3'b100
  } bst_e;

  bst_e st_q;
  row_t mem_q [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] init_q; // bucket written since reset
  row_t rd_q, row_rst, row_cur, row_new;
  cmd_t cmd_q;
  rsp_t rsp_q, rsp_d;
  logic done_q;
  logic wr;

  // reset image of a row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_rst[w] = '0;
      row_rst[w].rank = WW'(w);
    end
  end

  assign row_cur = init_q[BW'(cmd_q.bucket)] ? rd_q : row_rst;

  // compare all ways, build new row and result
  always_comb begin
    logic found, ffound;
    logic [WW-1:0] fw, vw, sw, r0;
    logic [5:0] sl;
    row_new = row_cur; found = 1'b0; ffound = 1'b0; fw = '0; vw = '0; wr = 1'b0;
    sw = WW'(cmd_q.req.buffer_index % 6'(WAYS));
    r0 = row_cur[sw].rank;
    rsp_d = '0;
    rsp_d.slot = cmd_q.req.buffer_index;
    for (int w = 0; w < WAYS; w++) begin
      if (row_cur[w].dev == cmd_q.req.device_id && row_cur[w].blk == cmd_q.req.block_number)
      begin
        if (!found || row_cur[w].rank > row_cur[fw].rank) fw = WW'(w);
        found = 1'b1;
      end
      if (row_cur[w].cnt == 8'd0) begin
        if (!ffound || row_cur[w].rank < row_cur[vw].rank) vw = WW'(w);
        ffound = 1'b1;
      end
    end
    sl = 6'(cmd_q.bucket * 6'(WAYS));
    if (cmd_q.req.kind == KIND_GET) begin
      if (found) begin
        rsp_d.slot = sl + 6'(fw); rsp_d.hit = 1'b1;
        if (row_cur[fw].cnt == 8'hFF) rsp_d.status = ST_SATURATED;
        else begin
          row_new[fw].cnt = row_cur[fw].cnt + 8'd1;
          rsp_d.needs_read = ~row_cur[fw].vld;
          row_new[fw].vld = 1'b1; wr = 1'b1;
        end
      end else if (ffound) begin
        rsp_d.slot = sl + 6'(vw); rsp_d.needs_read = 1'b1;
        row_new[vw].dev = cmd_q.req.device_id;
        row_new[vw].blk = cmd_q.req.block_number;
        row_new[vw].cnt = 8'd1; row_new[vw].vld = 1'b1; wr = 1'b1;
      end else begin
        rsp_d.slot = '0; rsp_d.status = ST_NO_FREE;
      end
    end else if (cmd_q.in_range) begin
      if (cmd_q.req.kind == KIND_PIN) begin
        if (row_cur[sw].cnt == 8'hFF) rsp_d.status = ST_SATURATED;
        else begin row_new[sw].cnt = row_cur[sw].cnt + 8'd1; wr = 1'b1; end
      end else if (row_cur[sw].cnt == 8'd0) rsp_d.status = ST_UNDERFLOW;
      else begin
        row_new[sw].cnt = row_cur[sw].cnt - 8'd1; wr = 1'b1;
        // release to zero: move to most recent
        if (cmd_q.req.kind == KIND_RELEASE && row_cur[sw].cnt == 8'd1) begin
          for (int w = 0; w < WAYS; w++)
            if (row_cur[w].rank > r0) row_new[w].rank = row_cur[w].rank - WW'(1);
          row_new[sw].rank = WW'(WAYS - 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; init_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        B_IDLE: if (!empty_i) st_q <= B_READ;
        B_READ: st_q <= B_EXEC;
        B_EXEC: begin
          st_q <= B_IDLE; done_q <= 1'b1;
          if (wr) init_q[BW'(cmd_q.bucket)] <= 1'b1;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  // bucket row memory, registered read
  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE && !empty_i) cmd_q <= cmd_i;
    if (st_q == B_READ) rd_q <= mem_q[BW'(cmd_q.bucket)];
    if (st_q == B_EXEC && wr) mem_q[BW'(cmd_q.bucket)] <= row_new;
    if (st_q == B_EXEC) rsp_q <= rsp_d;
  end

  assign pop_o = (st_q == B_IDLE) && !empty_i;
  assign idle_o = (st_q == B_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;
endmodule

[hdl/hashed_lru_block_buffer_cache.sv]
// Top level of the hashed LRU buffer cache tag store.
// Depends on hlbc_pkg, hlbc_front, hlbc_queue, hlbc_back, macros header.
// A request passes from the edge that accepts it to the edge that takes its
// result through the front end (bucket remainder from a registered
// reciprocal quotient, then the push into the queue) and the back end (pop,
// row read, compare and write back), and then done_o is shown. busy_o is
// high from an accept until the push, so the front end takes no new word
// until the last one is pushed; the back end keeps pace with the front end,
// so the queue does not fill. Results come on done_o for one
// cycle and cannot be stalled: the receiver must take every result word.
`timescale 1ns / 1ps
`include "hashed_lru_block_buffer_cache_macros.svh"
module hashed_lru_block_buffer_cache (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  hlbc_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output hlbc_pkg::rsp_t rsp_o
);
  import hlbc_pkg::*;
  logic push, full, empty, pop, idle;
  cmd_t cmd_f, cmd_b;

  hlbc_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .push_o(push), .cmd_o(cmd_f), .full_i(full));

  hlbc_queue u_queue (.clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_f),
    .full_o(full), .empty_o(empty), .pop_i(pop), .cmd_o(cmd_b));

  hlbc_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd_b), .pop_o(pop),
    .idle_o(idle), .done_o, .rsp_o);

  `HLBC_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push, !full)
  `HLBC_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop, !empty && idle)
  `HLBC_ASSERT_IMP(a_hit_slot, clk_i, rst_ni, done_o && rsp_o.status == ST_NO_FREE,
    rsp_o.slot == 6'd0 && !rsp_o.hit)
endmodule
